// File: rtl/core/itew_pkg.sv
// package for the integer to english word codes block
// types, word codes and sequencer encodings shared by all rtl files
`timescale 1ns / 1ps

package itew_pkg;

   typedef logic [30:0] number_type;
   typedef logic [4:0]  word_code_type;
   typedef logic [3:0]  digit_type;
   typedef logic [39:0] bcd_type;
   typedef logic [1:0]  group_type;

   // ten decimal digits, two input bits folded in per conversion step
   localparam int NUM_DIGITS = 10;
   localparam int CONV_STEPS = 16;

   localparam word_code_type WORD_ZERO      = 5'd0;
   localparam word_code_type WORD_TEN       = 5'd10;
   localparam word_code_type WORD_TENS_BASE = 5'd18;
   localparam word_code_type WORD_HUNDRED   = 5'd28;
   localparam word_code_type WORD_THOUSAND  = 5'd29;
   localparam word_code_type WORD_MILLION   = 5'd30;
   localparam word_code_type WORD_BILLION   = 5'd31;

   localparam group_type GROUP_BILLION  = 2'd0;
   localparam group_type GROUP_MILLION  = 2'd1;
   localparam group_type GROUP_THOUSAND = 2'd2;
   localparam group_type GROUP_UNITS    = 2'd3;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_CONV,
      SEQ_EMIT
   } seq_state_type;

   typedef enum logic [2:0] {
      POS_HUND,
      POS_HUNDRED,
      POS_TENS,
      POS_UNITS,
      POS_SCALE
   } pos_type;

   typedef struct packed {
      logic       start;
      number_type number;
   } conv_ctrl_type;

   typedef struct packed {
      logic    done;
      bcd_type bcd;
   } conv_stat_type;

endpackage

// File: rtl/core/itew_req_if.sv
// request channel carrying one number to spell
// depends on itew_pkg
`timescale 1ns / 1ps

interface itew_req_if;
   import itew_pkg::*;

   logic       valid;
   logic       ready;
   number_type number;

   modport source (output valid, output number, input ready);
   modport sink (input valid, input number, output ready);
endinterface

// File: rtl/core/itew_rsp_if.sv
// response channel carrying one word code per transfer
// depends on itew_pkg
`timescale 1ns / 1ps

interface itew_rsp_if;
   import itew_pkg::*;

   logic          valid;
   logic          ready;
   word_code_type word_code;
   logic          last;

   modport source (output valid, output word_code, output last, input ready);
   modport sink (input valid, input word_code, input last, output ready);
endinterface

// File: rtl/core/itew_bcd_conv.sv
// iterative binary to bcd converter, shift and add-3, two bits per cycle
// depends on itew_pkg
`timescale 1ns / 1ps

module itew_bcd_conv (
   input  logic                  clock,
   input  logic                  reset,
   input  itew_pkg::conv_ctrl_type ctrl,
   output itew_pkg::conv_stat_type stat
);
   import itew_pkg::*;

   localparam logic [3:0] LAST_STEP = 4'(CONV_STEPS - 1);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [31:0] sh_ff, sh_in;
   bcd_type     bcd_ff, bcd_in;
   bcd_type     step1, step1_sh, step2, bcd_step;

   function automatic bcd_type adjust(input bcd_type b);
      bcd_type r;
      r = b;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (b[4*i +: 4] >= 4'd5) begin
            r[4*i +: 4] = b[4*i +: 4] + 4'd3;
         end
      end
      return r;
   endfunction

   always_comb begin
      step1    = adjust(bcd_ff);
      step1_sh = {step1[38:0], sh_ff[31]};
      step2    = adjust(step1_sh);
      bcd_step = {step2[38:0], sh_ff[30]};

      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      sh_in   = sh_ff;
      bcd_in  = bcd_ff;
      done_in = busy_ff && (cnt_ff == LAST_STEP);
      if (ctrl.start) begin
         busy_in = 1'b1;
         cnt_in  = 4'd0;
         sh_in   = {1'b0, ctrl.number};
         bcd_in  = '0;
      end else if (busy_ff) begin
         bcd_in = bcd_step;
         sh_in  = {sh_ff[29:0], 2'b00};
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 4'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      sh_ff  <= sh_in;
      bcd_ff <= bcd_in;
   end

   assign stat.done = done_ff;
   assign stat.bcd  = bcd_ff;

endmodule

// File: rtl/core/itew_word_seq.sv
// word sequencer: walks groups and word positions, drives the output register
// depends on itew_pkg, itew_req_if, itew_rsp_if
`timescale 1ns / 1ps

module itew_word_seq (
   input  logic                    clock,
   input  logic                    reset,
   itew_req_if.sink                req_port,
   itew_rsp_if.source              rsp_port,
   output itew_pkg::conv_ctrl_type ctrl,
   input  itew_pkg::conv_stat_type stat
);
   import itew_pkg::*;

   seq_state_type state_ff, state_in;
   group_type     grp_ff, grp_in;
   pos_type       pos_ff, pos_in;
   logic          valid_ff;
   word_code_type word_ff, word_in;
   logic          last_ff, last_in;
   logic          load;
   logic          out_free;

   digit_type     h, t, u;
   logic [3:0]    nz;
   logic          lower_nz;
   logic [4:0]    ex;
   logic          later;
   logic          zero_num;
   logic          cur_ex;
   word_code_type scale_word;

   // digits of the current group
   always_comb begin
      case (grp_ff)
         GROUP_BILLION: begin
            h = 4'd0; t = 4'd0; u = stat.bcd[39:36];
         end
         GROUP_MILLION: begin
            h = stat.bcd[35:32]; t = stat.bcd[31:28]; u = stat.bcd[27:24];
         end
         GROUP_THOUSAND: begin
            h = stat.bcd[23:20]; t = stat.bcd[19:16]; u = stat.bcd[15:12];
         end
         default: begin
            h = stat.bcd[11:8]; t = stat.bcd[7:4]; u = stat.bcd[3:0];
         end
      endcase
   end

   always_comb begin
      nz[0]    = |stat.bcd[39:36];
      nz[1]    = |stat.bcd[35:24];
      nz[2]    = |stat.bcd[23:12];
      nz[3]    = |stat.bcd[11:0];
      zero_num = ~|nz;

      case (grp_ff)
         GROUP_BILLION:  lower_nz = |nz[3:1];
         GROUP_MILLION:  lower_nz = |nz[3:2];
         GROUP_THOUSAND: lower_nz = nz[3];
         default:        lower_nz = 1'b0;
      endcase

      case (grp_ff)
         GROUP_BILLION:  scale_word = WORD_BILLION;
         GROUP_MILLION:  scale_word = WORD_MILLION;
         GROUP_THOUSAND: scale_word = WORD_THOUSAND;
         default:        scale_word = WORD_ZERO;
      endcase

      ex[POS_HUND]    = (h != 4'd0);
      ex[POS_HUNDRED] = (h != 4'd0);
      ex[POS_TENS]    = (t != 4'd0);
      ex[POS_UNITS]   = (t != 4'd1) && (u != 4'd0);
      ex[POS_SCALE]   = (grp_ff != GROUP_UNITS) && nz[grp_ff];

      case (pos_ff)
         POS_HUND:    later = |ex[4:1];
         POS_HUNDRED: later = |ex[4:2];
         POS_TENS:    later = |ex[4:3];
         POS_UNITS:   later = ex[4];
         default:     later = 1'b0;
      endcase

      case (pos_ff)
         POS_HUND:    word_in = word_code_type'(h);
         POS_HUNDRED: word_in = WORD_HUNDRED;
         POS_TENS: begin
            if (t == 4'd1) begin
               word_in = WORD_TEN + word_code_type'(u);
            end else begin
               word_in = WORD_TENS_BASE + word_code_type'(t);
            end
         end
         POS_UNITS:   word_in = word_code_type'(u);
         default:     word_in = scale_word;
      endcase

      cur_ex  = ex[pos_ff];
      last_in = ~later & ~lower_nz;
      if (zero_num) begin
         cur_ex  = 1'b1;
         word_in = WORD_ZERO;
         last_in = 1'b1;
      end
   end

   assign out_free = !valid_ff || rsp_port.ready;

   always_comb begin
      state_in        = state_ff;
      grp_in          = grp_ff;
      pos_in          = pos_ff;
      load            = 1'b0;
      ctrl.start      = 1'b0;
      ctrl.number     = req_port.number;
      req_port.ready  = (state_ff == SEQ_IDLE);
      case (state_ff)
         SEQ_IDLE: begin
            if (req_port.valid) begin
               ctrl.start = 1'b1;
               state_in   = SEQ_CONV;
            end
         end
         SEQ_CONV: begin
            if (stat.done) begin
               state_in = SEQ_EMIT;
               grp_in   = GROUP_BILLION;
               pos_in   = POS_HUND;
            end
         end
         SEQ_EMIT: begin
            if (!cur_ex || out_free) begin
               load = cur_ex;
               if (cur_ex && last_in) begin
                  state_in = SEQ_IDLE;
               end else begin
                  case (pos_ff)
                     POS_HUND:    pos_in = POS_HUNDRED;
                     POS_HUNDRED: pos_in = POS_TENS;
                     POS_TENS:    pos_in = POS_UNITS;
                     POS_UNITS:   pos_in = POS_SCALE;
                     default: begin
                        pos_in = POS_HUND;
                        grp_in = grp_ff + 2'd1;
                     end
                  endcase
               end
            end
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         grp_ff   <= GROUP_BILLION;
         pos_ff   <= POS_HUND;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         grp_ff   <= grp_in;
         pos_ff   <= pos_in;
         if (load) begin
            valid_ff <= 1'b1;
         end else if (rsp_port.ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= word_in;
         last_ff <= last_in;
      end
   end

   assign rsp_port.valid     = valid_ff;
   assign rsp_port.word_code = word_ff;
   assign rsp_port.last      = last_ff;

   // the final word of a run returns the sequencer to idle
   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (load && last_in) |=> (state_ff == SEQ_IDLE))
      else $error("sequencer did not return to idle after final word");

   // conversion results only arrive while waiting for them
   a_done_in_conv: assert property (@(posedge clock) disable iff (reset)
      stat.done |-> (state_ff == SEQ_CONV))
      else $error("conversion done outside conversion state");

   // an accepted item blocks further input until its run completes
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_port.valid && req_port.ready) |=> !req_port.ready)
      else $error("input accepted while previous item in progress");

   // the tens position always yields a teen or tens word
   a_tens_word_range: assert property (@(posedge clock) disable iff (reset)
      (load && !zero_num && (pos_ff == POS_TENS)) |-> (word_in >= WORD_TEN))
      else $error("tens position produced a units word");

endmodule

// File: rtl/core/integer_to_english_word_codes.sv
// an accepted item first goes through the bcd converter (16 two-bit steps and the hand-off), then
// the group walk visits up to 19 word positions, each one whether the word is present or skipped;
// a zero item yields only the word zero; a present word waits for a free output register, so
// output stalls hold the walk; the next item is taken the cycle after its final word is loaded
// into the output register
// synchronous active-high reset returns to idle with no word pending
`timescale 1ns / 1ps

module integer_to_english_word_codes (
   input logic        clock,
   input logic        reset,
   itew_req_if.sink   req_port,
   itew_rsp_if.source rsp_port
);
   import itew_pkg::*;

   conv_ctrl_type ctrl;
   conv_stat_type stat;

   itew_bcd_conv u_conv (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .stat  (stat)
   );

   itew_word_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_port),
      .rsp_port (rsp_port),
      .ctrl     (ctrl),
      .stat     (stat)
   );

endmodule

// File: sim/itew_word_checker.sv
// checker for the integer to english word codes block: spells every accepted number
// into a queue of expected word codes and compares each accepted word against it
// depends on itew_pkg
`timescale 1ns / 1ps

module itew_word_checker
   import itew_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_ready,
   input  number_type    req_number,
   input  logic          rsp_valid,
   input  logic          rsp_ready,
   input  word_code_type rsp_word_code,
   input  logic          rsp_last,
   output int            mismatch_count,
   output int            words_outstanding,
   output int            words_checked
);

   localparam int unsigned ONE_BILLION  = 1000000000;
   localparam int unsigned ONE_MILLION  = 1000000;
   localparam int unsigned ONE_THOUSAND = 1000;
   localparam int          PRINT_LIMIT  = 20;

   typedef struct packed {
      number_type    number;
      word_code_type code;
      logic          last;
   } spoken_word_type;

   spoken_word_type expected_words [$];
   word_code_type   spelled_run [$];

   task report_mismatch(input string what);
      if (mismatch_count < PRINT_LIMIT) begin
         $display("mismatch at %0t: %s", $realtime, what);
      end
      mismatch_count++;
   endtask

   // one group of three digits, followed by its scale word when has_scale is set; zero groups say nothing
   task automatic spell_group(input int unsigned grp, input word_code_type scale_word,
                              input bit has_scale);
      int unsigned hund;
      int unsigned rest;
      hund = grp / 100;
      rest = grp % 100;
      if (grp == 0) begin
         return;
      end
      if (hund != 0) begin
         spelled_run.push_back(word_code_type'(hund));
         spelled_run.push_back(WORD_HUNDRED);
      end
      if (rest >= 20) begin
         spelled_run.push_back(WORD_TENS_BASE + word_code_type'(rest / 10));
         if (rest % 10 != 0) begin
            spelled_run.push_back(word_code_type'(rest % 10));
         end
      end else if (rest != 0) begin
         spelled_run.push_back(word_code_type'(rest));
      end
      if (has_scale) begin
         spelled_run.push_back(scale_word);
      end
   endtask

   task automatic spell_number(input number_type number);
      int unsigned     n;
      spoken_word_type word;
      n = number;
      spelled_run.delete();
      if (n == 0) begin
         spelled_run.push_back(WORD_ZERO);
      end else begin
         spell_group(n / ONE_BILLION, WORD_BILLION, 1'b1);
         n = n % ONE_BILLION;
         spell_group(n / ONE_MILLION, WORD_MILLION, 1'b1);
         n = n % ONE_MILLION;
         spell_group(n / ONE_THOUSAND, WORD_THOUSAND, 1'b1);
         spell_group(n % ONE_THOUSAND, WORD_ZERO, 1'b0);
      end
      for (int i = 0; i < spelled_run.size(); i++) begin
         word.number = number;
         word.code   = spelled_run[i];
         word.last   = (i == spelled_run.size() - 1);
         expected_words.push_back(word);
      end
   endtask

   always @(posedge clock) begin
      spoken_word_type heard;
      if (reset) begin
         expected_words.delete();
         mismatch_count = 0;
         words_checked  = 0;
      end else begin
         if (req_valid && req_ready) begin
            spell_number(req_number);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               report_mismatch($sformatf("word code %0d last %0b with no number pending",
                                         rsp_word_code, rsp_last));
            end else begin
               heard = expected_words.pop_front();
               if (rsp_word_code !== heard.code) begin
                  report_mismatch($sformatf("number %0d: word code %0d, expected %0d",
                                            heard.number, rsp_word_code, heard.code));
               end
               if (rsp_last !== heard.last) begin
                  report_mismatch($sformatf("number %0d: last %0b, expected %0b",
                                            heard.number, rsp_last, heard.last));
               end
               words_checked++;
            end
         end
      end
      words_outstanding = expected_words.size();
   end

endmodule

// File: sim/tb.sv
// top of the integer to english word codes testbench: clock, reset, number stimulus,
// random output back-pressure, watchdog and verdict
// depends on itew_pkg, itew_req_if, itew_rsp_if, the block and itew_word_checker
`timescale 1ns / 1ps

module tb;
   import itew_pkg::*;

   localparam int RANDOM_ITEMS     = 480;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int IDLE_LIMIT       = 3000;
   localparam int DRAIN_CYCLES     = 40;

   logic clock;
   logic reset;
   int   mismatch_count;
   int   words_outstanding;
   int   words_checked;
   int   numbers_sent;
   int   idle_cycles;
   bit   no_idling;
   bit   hold_request;

   itew_req_if req_ch ();
   itew_rsp_if rsp_ch ();

   integer_to_english_word_codes u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_ch),
      .rsp_port (rsp_ch)
   );

   itew_word_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_ch.valid),
      .req_ready         (req_ch.ready),
      .req_number        (req_ch.number),
      .rsp_valid         (rsp_ch.valid),
      .rsp_ready         (rsp_ch.ready),
      .rsp_word_code     (rsp_ch.word_code),
      .rsp_last          (rsp_ch.last),
      .mismatch_count    (mismatch_count),
      .words_outstanding (words_outstanding),
      .words_checked     (words_checked)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int idle_length();
      return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
   endfunction

   // groups biased toward zero, teens, round tens and round hundreds
   function automatic longint unsigned random_group();
      case ($urandom_range(0, 4))
         0: return 0;
         1: return 100 * $urandom_range(0, 9) + $urandom_range(10, 19);
         2: return 100 * $urandom_range(0, 9) + 10 * $urandom_range(2, 9);
         3: return 100 * $urandom_range(1, 9);
         default: return $urandom_range(0, 999);
      endcase
   endfunction

   function automatic number_type random_number();
      longint unsigned value;
      case ($urandom_range(0, 3))
         0: value = $urandom;
         1: value = $urandom_range(0, 999);
         2: value = $urandom_range(0, 999999);
         default: begin
            value = 64'd1000000000 * $urandom_range(0, 2) + 64'd1000000 * random_group()
                    + 64'd1000 * random_group() + random_group();
            if (value > 64'd2147483647) begin
               value = value - 64'd1000000000;
            end
         end
      endcase
      return number_type'(value);
   endfunction

   task send_number(input number_type value);
      int gap;
      gap = (no_idling || $urandom_range(0, 1) == 0) ? 0 : idle_length();
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.number <= value;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      numbers_sent++;
   endtask

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      int hold_left;
      int stall_left;
      hold_left  = 0;
      stall_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = LONG_HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (no_idling || $urandom_range(0, 3) != 0) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            stall_left = idle_length() - 1;
            rsp_ch.ready <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("integer_to_english_word_codes test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      number_type spot_checks [24];
      spot_checks = '{
         31'd0, 31'd1, 31'd9, 31'd10, 31'd11, 31'd19, 31'd20, 31'd21, 31'd40, 31'd99,
         31'd100, 31'd101, 31'd110, 31'd999, 31'd1000, 31'd1001, 31'd1000000,
         31'd1000001000, 31'd1000000000, 31'd1234567890, 31'd1777777777,
         31'd2000000000, 31'd2147483646, 31'd2147483647
      };
      idle_cycles   = 0;
      numbers_sent  = 0;
      no_idling     = 1'b0;
      hold_request  = 1'b0;
      reset         <= 1'b1;
      req_ch.valid  <= 1'b0;
      req_ch.number <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (spot_checks[i]) begin
         send_number(spot_checks[i]);
      end

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 120) begin
            hold_request = 1'b1;
         end
         // sender pause until every word is back
         if (i == 260) begin
            req_ch.valid <= 1'b0;
            do @(posedge clock); while (words_outstanding != 0);
         end
         no_idling = (i >= 340 && i < 420);
         send_number(random_number());
      end
      req_ch.valid <= 1'b0;

      do @(posedge clock); while (words_outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("spelled %0d numbers into %0d checked words: zero, teens, round tens,",
               numbers_sent, words_checked);
      $display("skipped groups, the 31-bit maximum, a long output hold-off and a burst");
      if (mismatch_count == 0 && words_outstanding == 0) begin
         $display("integer_to_english_word_codes test passed");
      end else begin
         $display("integer_to_english_word_codes test failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/itew_pkg.sv
rtl/core/itew_req_if.sv
rtl/core/itew_rsp_if.sv
rtl/core/itew_bcd_conv.sv
rtl/core/itew_word_seq.sv
rtl/core/integer_to_english_word_codes.sv
sim/itew_word_checker.sv
sim/tb.sv
